/* src/fth_pkg.sv */
// Package with the shared types, constants and hash step functions of the flow tuple hash.
`default_nettype none
package fth_pkg;

  // The bucket count must be a power of two, so that reductions are masks.
  localparam int unsigned HashBuckets = 256;
  localparam logic [31:0] BucketMask  = 32'(HashBuckets - 1);

  localparam logic [31:0] PjwTopMask   = 32'hf000_0000;
  localparam int unsigned PjwFoldShift = 24;
  localparam int unsigned PjwStepShift = 4;

  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;

  // Work in flight between the hash stages. Each endpoint keeps the two address
  // words still to be hashed; every mix stage consumes w0 and moves w1 down.
  typedef struct packed {
    logic        is_ipv6;
    logic [31:0] src_hash;
    logic [31:0] dst_hash;
    logic [63:0] src_w0;
    logic [63:0] src_w1;
    logic [63:0] dst_w0;
    logic [63:0] dst_w1;
  } stage_t;

  function automatic logic [31:0] pjw_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] n;
    logic [31:0] g;
    n = (h << PjwStepShift) + {24'd0, b};
    g = n & PjwTopMask;
    n = n ^ (g >> PjwFoldShift);
    n = n ^ g;
    return n;
  endfunction

  // Hashes the six bytes of v, most significant first.
  function automatic logic [31:0] pjw_bytes6(input logic [31:0] h, input logic [47:0] v);
    logic [31:0] n;
    n = h;
    for (int i = 5; i >= 0; i--) begin
      n = pjw_step(n, v[8*i +: 8]);
    end
    return n;
  endfunction

  // Hashes the eight bytes of v, most significant first.
  function automatic logic [31:0] pjw_bytes8(input logic [31:0] h, input logic [63:0] v);
    logic [31:0] n;
    n = h;
    for (int i = 7; i >= 0; i--) begin
      n = pjw_step(n, v[8*i +: 8]);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

/* src/fth_front.sv */
// First hash stage: port masking, the port bytes and the first four tuple bytes.
`default_nettype none
module fth_front import fth_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         valid_i,
  output logic              ready_o,
  input  wire logic         is_ipv6_i,
  input  wire logic [7:0]   protocol_i,
  input  wire logic [15:0]  src_port_i,
  input  wire logic [15:0]  dst_port_i,
  input  wire logic [63:0]  src_addr_hi_i,
  input  wire logic [63:0]  src_addr_lo_i,
  input  wire logic [63:0]  dst_addr_hi_i,
  input  wire logic [63:0]  dst_addr_lo_i,
  output logic              valid_o,
  input  wire logic         ready_i,
  output stage_t            data_o
);

  logic   valid_q;
  stage_t data_q, data_d;
  logic   ports_on;
  logic [15:0] sp, dp;
  logic [31:0] src_first, dst_first;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    ports_on = (protocol_i == ProtoTcp) || (protocol_i == ProtoUdp);
    sp = ports_on ? src_port_i : 16'd0;
    dp = ports_on ? dst_port_i : 16'd0;
    // An IPv6 endpoint carries four zero flowinfo bytes after the port.
    src_first = is_ipv6_i ? 32'd0 : src_addr_lo_i[31:0];
    dst_first = is_ipv6_i ? 32'd0 : dst_addr_lo_i[31:0];
    data_d.is_ipv6  = is_ipv6_i;
    data_d.src_hash = pjw_bytes6(32'd0, {sp, src_first});
    data_d.dst_hash = pjw_bytes6(32'd0, {dp, dst_first});
    data_d.src_w0   = src_addr_hi_i;
    data_d.src_w1   = src_addr_lo_i;
    data_d.dst_w0   = dst_addr_hi_i;
    data_d.dst_w1   = dst_addr_lo_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

/* src/fth_mix.sv */
// Mix stage: hashes eight address bytes per endpoint for IPv6 tuples.
`default_nettype none
module fth_mix import fth_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   valid_i,
  output logic        ready_o,
  input  wire stage_t data_i,
  output logic        valid_o,
  input  wire logic   ready_i,
  output stage_t      data_o
);

  logic   valid_q;
  stage_t data_q, data_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d = data_i;
    // IPv4 hashes are complete after the first stage and pass through unchanged.
    if (data_i.is_ipv6) begin
      data_d.src_hash = pjw_bytes8(data_i.src_hash, data_i.src_w0);
      data_d.dst_hash = pjw_bytes8(data_i.dst_hash, data_i.dst_w0);
    end
    data_d.src_w0 = data_i.src_w1;
    data_d.dst_w0 = data_i.dst_w1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

/* src/fth_reduce.sv */
// Output stage: reduces both endpoint hashes to buckets and combines them.
`default_nettype none
module fth_reduce import fth_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire stage_t      data_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output logic [7:0]       bucket_o
);

  logic        valid_q;
  logic [7:0]  bucket_q, bucket_d;
  logic [31:0] sum;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    // Both residues lie below the bucket count, so the sum cannot overflow.
    sum      = (data_i.src_hash & BucketMask) + (data_i.dst_hash & BucketMask);
    sum      = sum & BucketMask;
    bucket_d = sum[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      bucket_q <= bucket_d;
    end
  end

  assign valid_o  = valid_q;
  assign bucket_o = bucket_q;

endmodule
`default_nettype wire

/* src/flow_tuple_bucket_hash_top.sv */
// Throughput: one request per cycle unless the output stalls; the four register stages
// (front, two mix, reduce) each take a new request whenever they are empty or their
// successor takes one, and pass each request through in that order to m_axis.
// A stall at the output holds every full stage in place; nothing is dropped or repeated.
// Reset clears the stage valid bits at once; the data registers are not reset.
`default_nettype none
module flow_tuple_bucket_hash_top import fth_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // protocol[7:0], src_port[23:8], dst_port[39:24], src_addr_hi[103:40],
  // src_addr_lo[167:104], dst_addr_hi[231:168], dst_addr_lo[295:232]
  input  wire logic [295:0] s_axis_tdata,
  // is_ipv6[0]
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // bucket[7:0]
  output logic [7:0]        m_axis_tdata
);

  logic   v1, v2, v3;
  logic   r2, r3, r4;
  stage_t d1, d2, d3;

  fth_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s_axis_tvalid),
    .ready_o       (s_axis_tready),
    .is_ipv6_i     (s_axis_tuser),
    .protocol_i    (s_axis_tdata[7:0]),
    .src_port_i    (s_axis_tdata[23:8]),
    .dst_port_i    (s_axis_tdata[39:24]),
    .src_addr_hi_i (s_axis_tdata[103:40]),
    .src_addr_lo_i (s_axis_tdata[167:104]),
    .dst_addr_hi_i (s_axis_tdata[231:168]),
    .dst_addr_lo_i (s_axis_tdata[295:232]),
    .valid_o       (v1),
    .ready_i       (r2),
    .data_o        (d1)
  );

  fth_mix u_mix_hi (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1),
    .ready_o (r2),
    .data_i  (d1),
    .valid_o (v2),
    .ready_i (r3),
    .data_o  (d2)
  );

  fth_mix u_mix_lo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2),
    .ready_o (r3),
    .data_i  (d2),
    .valid_o (v3),
    .ready_i (r4),
    .data_o  (d3)
  );

  fth_reduce u_reduce (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (v3),
    .ready_o  (r4),
    .data_i   (d3),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .bucket_o (m_axis_tdata)
  );

endmodule
`default_nettype wire

/* src/fth_checker.sv */
// Port-level checker for the flow tuple hash, bound to the top level.
`default_nettype none
module fth_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [7:0]   m_axis_tdata
);

  localparam logic [2:0] Depth = 3'd4;

  logic [2:0] pending_q, pending_d;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_comb begin
    pending_d = pending_q + {2'd0, in_acc} - {2'd0, out_acc};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 3'd0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // A result is only offered for a request still outstanding.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pending_q != 3'd0)
    else $error("result offered with no request outstanding");

  // The four stages hold at most four requests, and when full with the output
  // stalled the input must be closed.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q == Depth) && !m_axis_tready |-> !s_axis_tready && pending_d == Depth)
    else $error("pipeline accepted a request while full and stalled");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped during a stall");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output data changed during a stall");

endmodule

bind flow_tuple_bucket_hash_top fth_checker u_fth_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the flow tuple bucket hash: random and corner tuples in, buckets checked.
module testbench;
  import fth_pkg::ProtoTcp;
  import fth_pkg::ProtoUdp;

  localparam int unsigned Buckets    = 256;
  localparam logic [31:0] ElfTopMask = 32'hf000_0000;
  localparam int unsigned ElfFold    = 24;
  localparam int unsigned ElfShift   = 4;
  localparam int unsigned RandomFlows = 800;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    logic        is_ipv6;
    logic [7:0]  protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
  } flow_tuple_t;

  // Holds the buckets still owed by the block, oldest first.
  class bucket_scoreboard;
    logic [7:0]  owed[$];
    int unsigned errors;

    function logic [31:0] elf_byte(logic [31:0] h, logic [7:0] b);
      logic [31:0] n;
      logic [31:0] top;
      n = (h << ElfShift) + {24'd0, b};
      top = n & ElfTopMask;
      if (top != 32'd0) begin
        n = n ^ (top >> ElfFold);
        n = n ^ top;
      end
      return n;
    endfunction

    // Feeds the lowest count bytes of v, the most significant of them first.
    function logic [31:0] elf_bytes(logic [31:0] h, logic [63:0] v, int count);
      logic [31:0] n;
      n = h;
      for (int i = count - 1; i >= 0; i--) begin
        n = elf_byte(n, v[8*i +: 8]);
      end
      return n;
    endfunction

    function logic [31:0] endpoint_bucket(logic v6, logic [15:0] port, logic [63:0] hi,
                                          logic [63:0] lo);
      logic [31:0] h;
      h = elf_bytes(32'd0, {48'd0, port}, 2);
      if (v6) begin
        h = elf_bytes(h, 64'd0, 4);
        h = elf_bytes(h, hi, 8);
        h = elf_bytes(h, lo, 8);
      end else begin
        h = elf_bytes(h, {32'd0, lo[31:0]}, 4);
      end
      return h % Buckets;
    endfunction

    function logic [7:0] flow_bucket(flow_tuple_t t);
      logic [15:0] sp;
      logic [15:0] dp;
      logic [31:0] sum;
      sp = 16'd0;
      dp = 16'd0;
      // Ports only take part for TCP and UDP.
      if (t.protocol == ProtoTcp || t.protocol == ProtoUdp) begin
        sp = t.src_port;
        dp = t.dst_port;
      end
      sum = endpoint_bucket(t.is_ipv6, sp, t.src_hi, t.src_lo)
          + endpoint_bucket(t.is_ipv6, dp, t.dst_hi, t.dst_lo);
      sum = sum % Buckets;
      return sum[7:0];
    endfunction

    function void note_request(flow_tuple_t t);
      owed.push_back(flow_bucket(t));
    endfunction

    function void check_bucket(logic [7:0] got);
      logic [7:0] want;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: bucket mismatch, expected none, actual %0d", $time, got);
      end else begin
        want = owed.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: bucket mismatch, expected %0d, actual %0d", $time, want, got);
        end
      end
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [295:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [7:0]   m_axis_tdata;

  logic        steady = 1'b0;
  int unsigned cycle_count = 0;
  bucket_scoreboard flow_buckets = new();

  flow_tuple_bucket_hash_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [295:0] pack_tuple(flow_tuple_t t);
    return {t.dst_lo, t.dst_hi, t.src_lo, t.src_hi, t.dst_port, t.src_port, t.protocol};
  endfunction

  function automatic flow_tuple_t unpack_tuple(logic [295:0] d, logic v6);
    flow_tuple_t t;
    t.is_ipv6  = v6;
    t.protocol = d[7:0];
    t.src_port = d[23:8];
    t.dst_port = d[39:24];
    t.src_hi   = d[103:40];
    t.src_lo   = d[167:104];
    t.dst_hi   = d[231:168];
    t.dst_lo   = d[295:232];
    return t;
  endfunction

  function automatic flow_tuple_t make_tuple(logic v6, logic [7:0] proto, logic [15:0] sp,
                                             logic [15:0] dp, logic [63:0] sh,
                                             logic [63:0] sl, logic [63:0] dh,
                                             logic [63:0] dl);
    flow_tuple_t t;
    t = '{v6, proto, sp, dp, sh, sl, dh, dl};
    return t;
  endfunction

  // Mostly fully random words, with the odd all-zero or all-one field.
  function automatic logic [63:0] random_word();
    int unsigned pick;
    pick = $urandom_range(19);
    if (pick == 0) return 64'd0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic flow_tuple_t random_tuple();
    flow_tuple_t t;
    int unsigned pick;
    pick = $urandom_range(9);
    t.is_ipv6 = 1'($urandom_range(1));
    if (pick < 4) t.protocol = ProtoTcp;
    else if (pick < 7) t.protocol = ProtoUdp;
    else t.protocol = 8'($urandom_range(255));
    t.src_port = 16'(random_word());
    t.dst_port = 16'(random_word());
    t.src_hi = random_word();
    t.src_lo = random_word();
    t.dst_hi = random_word();
    t.dst_lo = random_word();
    return t;
  endfunction

  function automatic logic take_pause();
    return !steady && ($urandom_range(99) < 14);
  endfunction

  task automatic send_tuple(input flow_tuple_t t);
    while (take_pause()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= t.is_ipv6;
    s_axis_tdata  <= pack_tuple(t);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (flow_buckets.pending() != 0) @(posedge clk_i);
  endtask

  task automatic send_corner_tuples();
    logic [63:0] ones;
    logic [63:0] alt;
    ones = '1;
    alt  = 64'haaaa_aaaa_aaaa_aaaa;
    send_tuple(make_tuple(1'b0, ProtoTcp, 16'h0000, 16'h0000, 64'd0, 64'd0, 64'd0, 64'd0));
    send_tuple(make_tuple(1'b0, ProtoUdp, 16'hffff, 16'hffff, ones, ones, ones, ones));
    send_tuple(make_tuple(1'b1, ProtoTcp, 16'hffff, 16'hffff, ones, ones, ones, ones));
    send_tuple(make_tuple(1'b1, ProtoUdp, 16'h0000, 16'h0000, 64'd0, 64'd0, 64'd0, 64'd0));
    send_tuple(make_tuple(1'b1, 8'd0, 16'hffff, 16'h1234, alt, ~alt, ~alt, alt));
    send_tuple(make_tuple(1'b1, 8'd255, 16'h8000, 16'h0001, alt, alt, ~alt, ~alt));
    send_tuple(make_tuple(1'b0, 8'd5, 16'hffff, 16'hffff, 64'd0, 64'hc0a8_0001,
                          64'd0, 64'h0a00_0001));
    send_tuple(make_tuple(1'b0, 8'd7, 16'h0050, 16'h01bb, 64'd0, 64'hc0a8_0001,
                          64'd0, 64'h0a00_0001));
    send_tuple(make_tuple(1'b0, 8'd16, 16'h0035, 16'hc000, ones, 64'hffff_ffff,
                          ones, 64'h0000_0000));
    send_tuple(make_tuple(1'b0, 8'd18, 16'h0035, 16'hc000, alt, 64'h7f00_0001,
                          ~alt, 64'h7f00_0001));
    // The upper halves of an IPv4 tuple must be ignored, so these two share a bucket.
    send_tuple(make_tuple(1'b0, ProtoTcp, 16'h1f90, 16'hd431, 64'd0, 64'hc0a8_0a0b,
                          64'd0, 64'h0808_0808));
    send_tuple(make_tuple(1'b0, ProtoTcp, 16'h1f90, 16'hd431, ones, 64'hdead_beef_c0a8_0a0b,
                          alt, 64'h1234_5678_0808_0808));
    send_tuple(make_tuple(1'b1, ProtoTcp, 16'h0016, 16'hffff, 64'h2001_0db8_0000_0000,
                          64'h0000_0000_0000_0001, 64'hfe80_0000_0000_0000,
                          64'h0211_22ff_fe33_4455));
    send_tuple(make_tuple(1'b1, ProtoUdp, 16'hffff, 16'h0000, ones, 64'd0, 64'd0, ones));
    send_tuple(make_tuple(1'b0, ProtoUdp, 16'h0000, 16'hffff, 64'd0, 64'hffff_ffff,
                          64'd0, 64'hffff_ffff));
    send_tuple(make_tuple(1'b1, 8'd1, 16'h0000, 16'h0000, ~alt, alt, alt, ~alt));
    send_tuple(make_tuple(1'b0, 8'd17, 16'h5555, 16'haaaa, 64'd0, 64'h5555_5555,
                          64'd0, 64'haaaa_aaaa));
    send_tuple(make_tuple(1'b1, 8'd6, 16'haaaa, 16'h5555, 64'h8000_0000_0000_0000,
                          64'h0000_0000_0000_0001, 64'h0000_0000_0000_0001,
                          64'h8000_0000_0000_0000));
  endtask

  // Output side: random back-pressure, none during the steady stretch.
  always @(posedge clk_i) begin
    m_axis_tready <= steady ? 1'b1 : ($urandom_range(99) >= 14);
  end

  // Both handshakes are sampled at the edge, before any update of that edge lands.
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      flow_buckets.note_request(unpack_tuple(s_axis_tdata, s_axis_tuser));
    end
    if (m_axis_tvalid && m_axis_tready) begin
      flow_buckets.check_bucket(m_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_corner_tuples();
    hold_until_drained();

    for (int n = 0; n < RandomFlows; n++) begin
      steady <= (n >= 300 && n < 480);
      if (n == 600) hold_until_drained();
      send_tuple(random_tuple());
    end

    steady <= 1'b0;
    hold_until_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (flow_buckets.errors == 0 && flow_buckets.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
